// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CELL_W = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_SET   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

endpackage

// ===== rtl/tcw_ram.sv =====
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/text_console_cell_writer_top.sv =====
`timescale 1ns / 1ps

// Text console engine: a COLUMNS x ROWS store of 16-bit cells (attribute over
// character) and a cursor, driven one command item at a time.
// Command channel: an item is taken at a clock edge with start high and busy
// low; opcode selects put character, clear, set cursor or read cell.
// Result channel: done is high for exactly one cycle per item, with
// cell_value, applied and the cursor (column, row, linear address) valid in
// that cycle. The receiver cannot stall; a result must be taken when shown.
// Item flow through the states, shaped by the store's single write port
// and its registered read port:
//   put without scroll, set cursor: done from S_EXEC;
//   read cell in range: S_EXEC, then S_READ (registered read of the store);
//   put that scrolls: S_EXEC, S_SCROLL, S_BLANK (one cell copied or blanked
//   per cycle); clear: S_CLEAR (one cell blanked per cycle).
// Reset: the cursor goes home and busy stays high while a clearing pass
// writes every cell to 0x0720; no result is shown for that pass.

module text_console_cell_writer_top #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [7:0]  char_code,
  input  logic [3:0]  fg_color,
  input  logic [3:0]  bg_color,
  input  logic [7:0]  target_col,
  input  logic [7:0]  target_row,
  output logic        done,
  output logic [15:0] cell_value,
  output logic [6:0]  cursor_col,
  output logic [4:0]  cursor_row,
  output logic [10:0] cursor_address,
  output logic        applied
);

  import tcw_pkg::*;

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS + 1);
  localparam int CT_W       = $clog2(COLUMNS + 8);
  localparam int SCROLL_END = (ROWS - 1) * COLUMNS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCROLL,
    S_BLANK
  } state_t;

  state_t state;

  logic [ADDR_W-1:0] idx;
  logic              clr_op;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;

  op_t        op_q;
  logic [7:0] ch_q;
  logic [7:0] attr_q;
  logic [7:0] tc_q;
  logic [7:0] tr_q;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] rdata;

  logic [CT_W-1:0]   col_ext;
  logic [CT_W-1:0]   col_next;
  logic              row_inc;
  logic [ROW_W-1:0]  row_next;
  logic              scroll_need;
  logic              wr_put;
  logic [COL_W-1:0]  wcol;
  logic [7:0]        wchar;
  logic              in_range;
  logic [ROW_W-1:0]  mul_row;
  logic [COL_W-1:0]  mul_col;
  logic [ADDR_W-1:0] calc_addr;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    col_ext  = CT_W'(cur_col);
    col_next = col_ext;
    row_inc  = 1'b0;
    wr_put   = 1'b0;
    wcol     = cur_col;
    wchar    = ch_q;
    case (ch_q)
      CH_NL: begin
        col_next = '0;
        row_inc  = 1'b1;
      end
      CH_CR: begin
        col_next = '0;
      end
      CH_TAB: begin
        col_next = (col_ext + CT_W'(8)) & ~CT_W'(7);
      end
      CH_BS: begin
        if (cur_col != '0) begin
          col_next = col_ext - CT_W'(1);
          wr_put   = 1'b1;
          wcol     = cur_col - COL_W'(1);
          wchar    = CH_SPACE;
        end
      end
      default: begin
        col_next = col_ext + CT_W'(1);
        wr_put   = 1'b1;
      end
    endcase
    if (col_next >= CT_W'(COLUMNS)) begin
      col_next = '0;
      row_inc  = 1'b1;
    end
    row_next    = cur_row + ROW_W'(row_inc);
    scroll_need = (row_next >= ROW_W'(ROWS));
  end

  assign in_range  = (tc_q < 8'(COLUMNS)) && (tr_q < 8'(ROWS));
  assign mul_row   = (op_q == OP_READ) ? ROW_W'(tr_q) : cur_row;
  assign mul_col   = (op_q == OP_READ) ? COL_W'(tc_q) : wcol;
  assign calc_addr = ADDR_W'(mul_row * COLUMNS + mul_col);

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = BLANK_CELL;
    raddr = calc_addr;
    unique case (state)
      S_CLEAR, S_BLANK: begin
        we = 1'b1;
      end
      S_EXEC: begin
        if ((op_q == OP_PUT) && wr_put) begin
          we    = 1'b1;
          waddr = calc_addr;
          wdata = {attr_q, wchar};
        end
      end
      S_SCROLL: begin
        raddr = idx + ADDR_W'(COLUMNS);
        we    = (idx != '0);
        waddr = idx - ADDR_W'(1);
        wdata = rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      idx     <= '0;
      clr_op  <= 1'b0;
      cur_col <= '0;
      cur_row <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (idx == ADDR_W'(CELLS - 1)) begin
            state   <= S_IDLE;
            cur_col <= '0;
            cur_row <= '0;
            if (clr_op) begin
              done       <= 1'b1;
              cell_value <= '0;
              applied    <= 1'b1;
            end
          end else begin
            idx <= idx + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            op_q   <= op_t'(opcode);
            ch_q   <= char_code;
            attr_q <= {bg_color, fg_color};
            tc_q   <= target_col;
            tr_q   <= target_row;
            if (op_t'(opcode) == OP_CLEAR) begin
              state  <= S_CLEAR;
              idx    <= '0;
              clr_op <= 1'b1;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          unique case (op_q)
            OP_PUT: begin
              cur_col <= COL_W'(col_next);
              if (scroll_need) begin
                cur_row <= ROW_W'(ROWS - 1);
                idx     <= '0;
                state   <= S_SCROLL;
              end else begin
                cur_row    <= row_next;
                done       <= 1'b1;
                cell_value <= '0;
                applied    <= 1'b1;
                state      <= S_IDLE;
              end
            end
            OP_SET: begin
              if (in_range) begin
                cur_col <= COL_W'(tc_q);
                cur_row <= ROW_W'(tr_q);
              end
              done       <= 1'b1;
              cell_value <= '0;
              applied    <= in_range;
              state      <= S_IDLE;
            end
            OP_READ: begin
              if (in_range) begin
                state <= S_READ;
              end else begin
                done       <= 1'b1;
                cell_value <= '0;
                applied    <= 1'b0;
                state      <= S_IDLE;
              end
            end
            default: begin
              done       <= 1'b1;
              cell_value <= '0;
              applied    <= 1'b1;
              state      <= S_IDLE;
            end
          endcase
        end
        S_READ: begin
          done       <= 1'b1;
          cell_value <= rdata;
          applied    <= 1'b1;
          state      <= S_IDLE;
        end
        S_SCROLL: begin
          if (idx == ADDR_W'(SCROLL_END)) begin
            state <= S_BLANK;
          end else begin
            idx <= idx + ADDR_W'(1);
          end
        end
        S_BLANK: begin
          if (idx == ADDR_W'(CELLS - 1)) begin
            done       <= 1'b1;
            cell_value <= '0;
            applied    <= 1'b1;
            state      <= S_IDLE;
          end else begin
            idx <= idx + ADDR_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state != S_IDLE);
  assign cursor_col     = 7'(cur_col);
  assign cursor_row     = 5'(cur_row);
  assign cursor_address = 11'(cur_row * COLUMNS + cur_col);

endmodule

// ===== dv/tcw_console_checker.sv =====
`timescale 1ns / 1ps

module tcw_console_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  opcode,
  input  logic [7:0]  char_code,
  input  logic [3:0]  fg_color,
  input  logic [3:0]  bg_color,
  input  logic [7:0]  target_col,
  input  logic [7:0]  target_row,
  input  logic        done,
  input  logic [15:0] cell_value,
  input  logic [6:0]  cursor_col,
  input  logic [4:0]  cursor_row,
  input  logic [10:0] cursor_address,
  input  logic        applied,
  output int          fail_count,
  output int          pending
);
  import tcw_pkg::*;

  typedef struct packed {
    logic [15:0] cell_val;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] addr;
    logic        applied;
  } status_t;

  logic [15:0] cell_store [COLUMNS*ROWS];
  int          pred_col = 0;
  int          pred_row = 0;
  int          errors   = 0;
  status_t     expected_status_q [$];
  status_t     want;

  function automatic void blank_store();
    for (int i = 0; i < COLUMNS * ROWS; i++) cell_store[i] = BLANK_CELL;
  endfunction

  function automatic void scroll_store();
    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) cell_store[i] = cell_store[i + COLUMNS];
    for (int i = (ROWS - 1) * COLUMNS; i < COLUMNS * ROWS; i++) cell_store[i] = BLANK_CELL;
  endfunction

  function automatic void put_char(logic [7:0] ch, logic [7:0] attr);
    case (ch)
      CH_NL: begin
        pred_col = 0;
        pred_row++;
      end
      CH_CR: pred_col = 0;
      CH_TAB: pred_col = (pred_col + 8) & ~7;
      CH_BS: begin
        if (pred_col > 0) begin
          pred_col--;
          cell_store[pred_row * COLUMNS + pred_col] = {attr, CH_SPACE};
        end
      end
      default: begin
        cell_store[pred_row * COLUMNS + pred_col] = {attr, ch};
        pred_col++;
      end
    endcase
    if (pred_col >= COLUMNS) begin
      pred_col = 0;
      pred_row++;
    end
    if (pred_row >= ROWS) begin
      scroll_store();
      pred_row = ROWS - 1;
    end
  endfunction

  function automatic status_t apply_command(op_t op, logic [7:0] ch, logic [3:0] fg,
                                            logic [3:0] bg, logic [7:0] tc, logic [7:0] tr);
    status_t res;
    logic    in_range;
    res         = '0;
    res.applied = 1'b1;
    in_range    = (tc < COLUMNS) && (tr < ROWS);
    case (op)
      OP_PUT: put_char(ch, {bg, fg});
      OP_CLEAR: begin
        blank_store();
        pred_col = 0;
        pred_row = 0;
      end
      OP_SET: begin
        if (in_range) begin
          pred_col = int'(tc);
          pred_row = int'(tr);
        end else begin
          res.applied = 1'b0;
        end
      end
      default: begin
        if (in_range) res.cell_val = cell_store[tr * COLUMNS + tc];
        else res.applied = 1'b0;
      end
    endcase
    res.col  = 7'(pred_col);
    res.row  = 5'(pred_row);
    res.addr = 11'(pred_row * COLUMNS + pred_col);
    return res;
  endfunction

  task automatic check_field(string field, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      blank_store();
      pred_col = 0;
      pred_row = 0;
      expected_status_q.delete();
    end else begin
      if (done) begin
        if (expected_status_q.size() == 0) begin
          $display("%0t: result with no item waiting, actual cell 0x%0h col %0d row %0d",
                   $time, cell_value, cursor_col, cursor_row);
          errors++;
        end else begin
          want = expected_status_q.pop_front();
          check_field("cell_value", want.cell_val, cell_value);
          check_field("cursor_col", 16'(want.col), 16'(cursor_col));
          check_field("cursor_row", 16'(want.row), 16'(cursor_row));
          check_field("cursor_address", 16'(want.addr), 16'(cursor_address));
          check_field("applied", 16'(want.applied), 16'(applied));
        end
      end
      if (start && !busy) begin
        expected_status_q.push_back(apply_command(op_t'(opcode), char_code, fg_color,
                                                  bg_color, target_col, target_row));
      end
    end
    pending    <= expected_status_q.size();
    fail_count <= errors;
  end

endmodule

// ===== dv/tb_text_console_cell_writer_top.sv =====
`timescale 1ns / 1ps

module tb_text_console_cell_writer_top;
  import tcw_pkg::*;

  localparam int COLUMNS      = COLUMNS_DEF;
  localparam int ROWS         = ROWS_DEF;
  localparam int RANDOM_ITEMS = 500;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        start      = 1'b0;
  logic [1:0]  opcode     = OP_PUT;
  logic [7:0]  char_code  = '0;
  logic [3:0]  fg_color   = '0;
  logic [3:0]  bg_color   = '0;
  logic [7:0]  target_col = '0;
  logic [7:0]  target_row = '0;
  logic        busy;
  logic        done;
  logic [15:0] cell_value;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic [10:0] cursor_address;
  logic        applied;
  int          fail_count;
  int          pending;
  int          idle_pct = 0;
  logic [6:0]  seen_col = '0;
  logic [4:0]  seen_row = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  text_console_cell_writer_top #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .char_code     (char_code),
    .fg_color      (fg_color),
    .bg_color      (bg_color),
    .target_col    (target_col),
    .target_row    (target_row),
    .done          (done),
    .cell_value    (cell_value),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .cursor_address(cursor_address),
    .applied       (applied)
  );

  tcw_console_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .char_code     (char_code),
    .fg_color      (fg_color),
    .bg_color      (bg_color),
    .target_col    (target_col),
    .target_row    (target_row),
    .done          (done),
    .cell_value    (cell_value),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .cursor_address(cursor_address),
    .applied       (applied),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // track the cursor so reads land near freshly written text
  always @(posedge clk) begin
    if (done) begin
      seen_col <= cursor_col;
      seen_row <= cursor_row;
    end
  end

  task automatic send_cmd(op_t op, logic [7:0] ch, logic [3:0] fg, logic [3:0] bg,
                          logic [7:0] tc, logic [7:0] tr);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(8, 1);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode     <= op;
    char_code  <= ch;
    fg_color   <= fg;
    bg_color   <= bg;
    target_col <= tc;
    target_row <= tr;
    start      <= 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_cmd();
    int         pick;
    int         sel;
    logic [7:0] ch;
    logic [7:0] tc;
    logic [7:0] tr;
    pick = $urandom_range(99);
    sel  = $urandom_range(99);
    ch   = 8'($urandom_range(255));
    tc   = 8'($urandom_range(255));
    tr   = 8'($urandom_range(255));
    if (pick < 58) begin
      if (sel < 10) ch = CH_NL;
      else if (sel < 15) ch = CH_CR;
      else if (sel < 21) ch = CH_TAB;
      else if (sel < 29) ch = CH_BS;
      send_cmd(OP_PUT, ch, 4'($urandom_range(15)), 4'($urandom_range(15)), tc, tr);
    end else if (pick < 59) begin
      send_cmd(OP_CLEAR, ch, 4'($urandom_range(15)), 4'($urandom_range(15)), tc, tr);
    end else if (pick < 72) begin
      if (sel < 80) begin
        tc = 8'($urandom_range(COLUMNS - 1));
        tr = 8'(($urandom_range(99) < 30) ? $urandom_range(ROWS - 1, ROWS - 2)
                                          : $urandom_range(ROWS - 1));
      end
      send_cmd(OP_SET, ch, 4'($urandom_range(15)), 4'($urandom_range(15)), tc, tr);
    end else begin
      if (sel < 45) begin
        tc = 8'(seen_col - $urandom_range((seen_col < 4) ? seen_col : 4));
        tr = 8'(seen_row);
      end else if (sel < 85) begin
        tc = 8'($urandom_range(COLUMNS - 1));
        tr = 8'($urandom_range(ROWS - 1));
      end
      send_cmd(OP_READ, ch, 4'($urandom_range(15)), 4'($urandom_range(15)), tc, tr);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_cmd(OP_READ,  8'h00,  4'h0, 4'h0, 8'd0,   8'd0);
    send_cmd(OP_PUT,   8'h41,  4'hF, 4'hF, 8'd0,   8'd0);
    send_cmd(OP_PUT,   8'h00,  4'h0, 4'h0, 8'd0,   8'd0);
    send_cmd(OP_PUT,   8'hFF,  4'hF, 4'h0, 8'd0,   8'd0);
    send_cmd(OP_PUT,   CH_BS,  4'h2, 4'h5, 8'd0,   8'd0);
    send_cmd(OP_READ,  8'h00,  4'h0, 4'h0, 8'd2,   8'd0);
    send_cmd(OP_PUT,   CH_CR,  4'h1, 4'h1, 8'd0,   8'd0);
    send_cmd(OP_PUT,   CH_BS,  4'h3, 4'h4, 8'd0,   8'd0);
    send_cmd(OP_PUT,   CH_TAB, 4'h0, 4'h0, 8'd0,   8'd0);
    send_cmd(OP_SET,   8'h00,  4'h0, 4'h0, 8'd79,  8'd0);
    send_cmd(OP_PUT,   8'h78,  4'hA, 4'h0, 8'd0,   8'd0);
    send_cmd(OP_SET,   8'h00,  4'h0, 4'h0, 8'd80,  8'd0);
    send_cmd(OP_SET,   8'h00,  4'h0, 4'h0, 8'd0,   8'd25);
    send_cmd(OP_SET,   8'h00,  4'h0, 4'h0, 8'd255, 8'd255);
    send_cmd(OP_READ,  8'h00,  4'h0, 4'h0, 8'd80,  8'd24);
    send_cmd(OP_READ,  8'h00,  4'h0, 4'h0, 8'd79,  8'd0);
    send_cmd(OP_SET,   8'h00,  4'h0, 4'h0, 8'd5,   8'd24);
    send_cmd(OP_PUT,   CH_NL,  4'h7, 4'h0, 8'd0,   8'd0);
    send_cmd(OP_SET,   8'h00,  4'h0, 4'h0, 8'd79,  8'd24);
    send_cmd(OP_PUT,   8'h7A,  4'hC, 4'h9, 8'd0,   8'd0);
    send_cmd(OP_READ,  8'h00,  4'h0, 4'h0, 8'd79,  8'd23);
    send_cmd(OP_SET,   8'h00,  4'h0, 4'h0, 8'd77,  8'd24);
    send_cmd(OP_PUT,   CH_TAB, 4'h0, 4'h0, 8'd0,   8'd0);
    send_cmd(OP_CLEAR, 8'h00,  4'h0, 4'h0, 8'd0,   8'd0);
    send_cmd(OP_READ,  8'h00,  4'h0, 4'h0, 8'd79,  8'd23);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 78 : (ph == 2) ? 33 : 0;
      repeat (RANDOM_ITEMS / 4) send_random_cmd();
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (2100) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
